// ----- rtl/core/sfp_pkg.sv -----
// Shared types and constants for the sync-header frame parser.
// Used by sfp_ctrl, sfp_datapath and sync_header_frame_parser; no dependencies.
package sfp_pkg;

  // Frame geometry
  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h0A;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID     = 2'd1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  // Parser states; the first nine follow the frame layout
  typedef enum logic [3:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_SYNC2,
    ST_SYNC3,
    ST_LEN,
    ST_ID,
    ST_DATA,
    ST_SUM,
    ST_END,
    ST_RD,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic [1:0] sync_sel;     // which sync byte to compare against
    logic       start_sum;    // length byte accepted
    logic       add_sum;      // accumulate rx byte
    logic       clr_count;    // start of payload
    logic       store;        // write payload byte
    logic       load_rx_sum;  // capture received checksum
    logic       frame_good;   // good frame end
    logic       frame_bad;    // bad frame end, load reject item
    logic       rd_start;     // reset replay index
    logic       rd_issue;     // read store at replay index
    logic       out_payload;  // load replayed byte into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sync_hit;
    logic len_hit;
    logic id_hit;
    logic data_done;
    logic end_good;
    logic out_free;
    logic rd_last;
  } stat_t;

  // Sync sequence '$','D','A','T'
  function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] sel);
    logic [BYTE_W-1:0] b;
    case (sel)
      2'd0:    b = 8'h24;
      2'd1:    b = 8'h44;
      2'd2:    b = 8'h41;
      2'd3:    b = 8'h54;
      default: b = 8'h24;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/sfp_ctrl.sv -----
// Parser state machine: walks the frame and sequences the payload replay.
// Depends on sfp_pkg; drives cmd_t to sfp_datapath and reads its stat_t.
module sfp_ctrl
  import sfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   take;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC0;
    end else begin
      state <= state_next;
    end
  end

  // Input stalls during replay, and at frame end while the output is full
  always_comb begin
    in_stall = (state == ST_RD) || (state == ST_OUT) ||
               ((state == ST_END) && !stat.out_free);
  end

  assign take = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_SYNC0, ST_SYNC1, ST_SYNC2, ST_SYNC3: begin
        cmd.sync_sel = state[1:0];
        if (take) begin
          if (!stat.sync_hit) begin
            state_next = ST_SYNC0;
          end else begin
            case (state)
              ST_SYNC0: state_next = ST_SYNC1;
              ST_SYNC1: state_next = ST_SYNC2;
              ST_SYNC2: state_next = ST_SYNC3;
              default:  state_next = ST_LEN;
            endcase
          end
        end
      end
      ST_LEN: begin
        if (take) begin
          if (stat.len_hit) begin
            cmd.start_sum = 1'b1;
            state_next    = ST_ID;
          end else begin
            state_next = ST_SYNC0;
          end
        end
      end
      ST_ID: begin
        if (take) begin
          if (stat.id_hit) begin
            cmd.add_sum   = 1'b1;
            cmd.clr_count = 1'b1;
            state_next    = ST_DATA;
          end else begin
            state_next = ST_SYNC0;
          end
        end
      end
      ST_DATA: begin
        if (take) begin
          cmd.store   = 1'b1;
          cmd.add_sum = 1'b1;
          if (stat.data_done) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (take) begin
          cmd.load_rx_sum = 1'b1;
          state_next      = ST_END;
        end
      end
      ST_END: begin
        if (take) begin
          if (stat.end_good) begin
            cmd.frame_good = 1'b1;
            cmd.rd_start   = 1'b1;
            state_next     = ST_RD;
          end else begin
            cmd.frame_bad = 1'b1;
            state_next    = ST_SYNC0;
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_payload = 1'b1;
          state_next      = stat.rd_last ? ST_SYNC0 : ST_RD;
        end
      end
      default: begin
        state_next = ST_SYNC0;
      end
    endcase
  end

endmodule

// ----- rtl/core/sfp_datapath.sv -----
// Parser datapath: config registers, checksum, payload store, frame
// counters and the output register. Depends on sfp_pkg; driven by sfp_ctrl.
module sfp_datapath
  import sfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 kind,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [ADDR_W-1:0]    byte_index,
  output logic                 last,
  output logic [CNT_W-1:0]     good_count,
  output logic [CNT_W-1:0]     error_count
);

  logic [LEN_W-1:0]  payload_length;
  logic [BYTE_W-1:0] message_id;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] received_sum;
  logic [LEN_W-1:0]  payload_count;
  logic [LEN_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] rd_q;
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  bad_frames;
  logic [BYTE_W-1:0] payload_store [MAX_PAYLOAD];
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  count_inc;

  // Expected length byte is the effective length plus one
  function automatic logic [LEN_W-1:0] count_w_len(input logic [LEN_W-1:0] n);
    return n + LEN_W'(1);
  endfunction

  // Configuration registers, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= LEN_W'(16);
      message_id     <= BYTE_W'(2);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PAYLOAD_LENGTH) begin
        payload_length <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == CFG_MESSAGE_ID) begin
        message_id <= cfg_data;
      end
    end
  end

  // Effective length clamped to 1..MAX_PAYLOAD
  always_comb begin
    if (payload_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (payload_length > LEN_W'(MAX_PAYLOAD)) begin
      eff_len = LEN_W'(MAX_PAYLOAD);
    end else begin
      eff_len = payload_length;
    end
  end

  assign count_inc = payload_count + LEN_W'(1);

  // Status back to the controller
  always_comb begin
    stat.sync_hit  = (rx_byte == sync_byte(cmd.sync_sel));
    stat.len_hit   = (rx_byte == {1'b0, count_w_len(eff_len)});
    stat.id_hit    = (rx_byte == message_id);
    stat.data_done = (count_inc >= eff_len);
    stat.end_good  = (running_sum == received_sum) && (rx_byte == TERMINATOR);
    stat.out_free  = !out_valid || !out_stall;
    stat.rd_last   = ((rd_idx + LEN_W'(1)) == payload_count);
  end

  // Checksum and payload count
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      received_sum  <= '0;
      payload_count <= '0;
    end else begin
      if (cmd.start_sum) begin
        running_sum <= rx_byte;
      end else if (cmd.add_sum) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.load_rx_sum) begin
        received_sum <= rx_byte;
      end
      if (cmd.clr_count) begin
        payload_count <= '0;
      end else if (cmd.store) begin
        payload_count <= count_inc;
      end
    end
  end

  // Payload store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      payload_store[payload_count[ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_q <= payload_store[rd_idx[ADDR_W-1:0]];
    end
  end

  // Replay index
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_start) begin
      rd_idx <= '0;
    end else if (cmd.out_payload) begin
      rd_idx <= rd_idx + LEN_W'(1);
    end
  end

  // Frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      good_frames <= '0;
      bad_frames  <= '0;
    end else begin
      if (cmd.frame_good) begin
        good_frames <= good_frames + CNT_W'(1);
      end
      if (cmd.frame_bad) begin
        bad_frames <= bad_frames + CNT_W'(1);
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.frame_bad || cmd.out_payload) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: item fields
  always_ff @(posedge clk) begin
    if (cmd.frame_bad) begin
      kind         <= KIND_REJECT;
      payload_byte <= '0;
      byte_index   <= '0;
      last         <= 1'b1;
      good_count   <= good_frames;
      error_count  <= bad_frames + CNT_W'(1);
    end else if (cmd.out_payload) begin
      kind         <= KIND_PAYLOAD;
      payload_byte <= rd_q;
      byte_index   <= rd_idx[ADDR_W-1:0];
      last         <= stat.rd_last;
      good_count   <= good_frames;
      error_count  <= bad_frames;
    end
  end

endmodule

// ----- rtl/core/sync_header_frame_parser.sv -----
// Sync-header frame parser: top level joining controller and datapath.
// Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
//
// Input channel: one received byte per item (in_valid, in_stall, rx_byte).
// A frame is '$','D','A','T', length (clamped payload_length+1), ID (message_id),
// the payload, an additive checksum byte and a 0x0A terminator.
// Output channel (out_valid, out_stall): on a good frame end, one item per
// stored payload byte with last set on the final one; on a bad frame end,
// one reject item. Each item carries the wrapping good/error frame counts.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// write only while the parser is idle.
// Throughput: one byte per cycle while parsing and in_stall is low. A good frame
// end replays the store one byte at a time, each through a registered memory read
// (ST_RD) and an output load (ST_OUT) when the output is free, in_stall held high.
// A bad frame end loads its reject item into the output register directly.
// Reset: parser waits for '$', counters and sums clear, payload_length = 16,
// message_id = 2. A stalled receiver holds the output register; the parser
// keeps taking bytes until it needs the output register again.
module sync_header_frame_parser
  import sfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [ADDR_W-1:0]    byte_index,
  output logic                 last,
  output logic [CNT_W-1:0]     good_count,
  output logic [CNT_W-1:0]     error_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // Frame state machine
  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Checksum, store, counters and output register
  sfp_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last),
    .good_count   (good_count),
    .error_count  (error_count)
  );

endmodule

// ----- tb/sfp_checker.sv -----
// Checker for sync_header_frame_parser: follows the config, input and output channels,
// predicts the result items of every accepted byte and compares them in order.
// Depends on sfp_pkg for widths, the parser state enum and the result kinds.
module sfp_checker
  import sfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 kind,
  input  logic [BYTE_W-1:0]    payload_byte,
  input  logic [ADDR_W-1:0]    byte_index,
  input  logic                 last,
  input  logic [CNT_W-1:0]     good_count,
  input  logic [CNT_W-1:0]     error_count,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  // '$','D','A','T', first byte in the top lane
  localparam logic [31:0] SYNC_WORD = 32'h2444_4154;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [ADDR_W-1:0] index;
    logic              last;
    logic [CNT_W-1:0]  good;
    logic [CNT_W-1:0]  bad;
  } frame_result_t;

  frame_result_t expected_q[$];

  // Predicted parser state and register copies
  state_t            phase;
  logic [BYTE_W-1:0] frame_sum;
  logic [BYTE_W-1:0] rx_checksum;
  int unsigned       stored;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
  logic [CNT_W-1:0]  good_frames;
  logic [CNT_W-1:0]  bad_frames;
  logic [LEN_W-1:0]  len_reg;
  logic [BYTE_W-1:0] id_reg;

  // Register value 0 acts as 1, anything above the store size as the store size
  function automatic int unsigned frame_len(input logic [LEN_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_PAYLOAD) return MAX_PAYLOAD;
    return r;
  endfunction

  task automatic clear_parser();
    phase       = ST_SYNC0;
    frame_sum   = '0;
    rx_checksum = '0;
    stored      = 0;
    good_frames = '0;
    bad_frames  = '0;
    len_reg     = 7'd16;
    id_reg      = 8'h02;
    fail_count  = 0;
    expected_q.delete();
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
    if (idx == CFG_PAYLOAD_LENGTH) begin
      len_reg = d[LEN_W-1:0];
    end else if (idx == CFG_MESSAGE_ID) begin
      id_reg = d;
    end
  endtask

  // Advance the frame walk by one byte, queueing whatever results the byte causes
  task automatic take_byte(input logic [BYTE_W-1:0] b);
    int unsigned   n;
    frame_result_t r;
    n = frame_len(len_reg);
    case (phase)
      ST_SYNC0, ST_SYNC1, ST_SYNC2, ST_SYNC3: begin
        // a mismatch drops the byte, even a fresh '$'
        if (b == SYNC_WORD[31 - 8*int'(phase) -: 8]) phase = state_t'(phase + 1);
        else phase = ST_SYNC0;
      end
      ST_LEN: begin
        if (int'(b) == n + 1) begin
          frame_sum = b;
          phase     = ST_ID;
        end else begin
          phase = ST_SYNC0;
        end
      end
      ST_ID: begin
        if (b == id_reg) begin
          frame_sum = frame_sum + b;
          stored    = 0;
          phase     = ST_DATA;
        end else begin
          phase = ST_SYNC0;
        end
      end
      ST_DATA: begin
        if (stored < MAX_PAYLOAD) begin
          payload_mem[stored[ADDR_W-1:0]] = b;
          frame_sum = frame_sum + b;
          stored++;
          // length is taken as it stands now
          if (stored >= n) phase = ST_SUM;
        end else begin
          phase = ST_SYNC0;
        end
      end
      ST_SUM: begin
        rx_checksum = b;
        phase       = ST_END;
      end
      ST_END: begin
        if (frame_sum == rx_checksum && b == TERMINATOR) begin
          good_frames = good_frames + 1'b1;
          for (int k = 0; k < stored; k++) begin
            r.kind  = KIND_PAYLOAD;
            r.data  = payload_mem[k[ADDR_W-1:0]];
            r.index = k[ADDR_W-1:0];
            r.last  = (k + 1 == stored);
            r.good  = good_frames;
            r.bad   = bad_frames;
            expected_q.push_back(r);
          end
        end else begin
          bad_frames = bad_frames + 1'b1;
          r.kind  = KIND_REJECT;
          r.data  = '0;
          r.index = '0;
          r.last  = 1'b1;
          r.good  = good_frames;
          r.bad   = bad_frames;
          expected_q.push_back(r);
        end
        phase = ST_SYNC0;
      end
      default: phase = ST_SYNC0;
    endcase
  endtask

  // Compare one output item against the oldest prediction
  task automatic check_result();
    frame_result_t got;
    frame_result_t want;
    got = {kind, payload_byte, byte_index, last, good_count, error_count};
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected item kind=%0d byte=%02h idx=%0d last=%0d good=%0d err=%0d",
                 $time, got.kind, got.data, got.index, got.last, got.good, got.bad);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: item mismatch exp kind=%0d byte=%02h idx=%0d last=%0d good=%0d err=%0d%s",
                   $time, want.kind, want.data, want.index, want.last, want.good, want.bad,
                   $sformatf(" / got kind=%0d byte=%02h idx=%0d last=%0d good=%0d err=%0d",
                             got.kind, got.data, got.index, got.last, got.good, got.bad));
      end
    end
  endtask

  // Config and input are taken before output; an item never answers a byte of the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_byte(rx_byte);
      if (out_valid && !out_stall) check_result();
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/sync_header_frame_parser_tb.sv -----
// Testbench top for sync_header_frame_parser: clock, reset, frame stimulus and verdict.
// Depends on sfp_pkg, the parser RTL and sfp_checker, which predicts and compares.
module sync_header_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfp_pkg::*;

  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          SETTLE_CYCLES = 2*MAX_PAYLOAD + 8;
  localparam int          PHASE_BYTES   = 16;
  localparam int          NUM_PHASES    = 11;
  localparam logic [31:0] SYNC_WORD     = 32'h2444_4154;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_BAD_LEN, FR_BAD_ID, FR_BROKEN_SYNC, FR_NOISE
  } frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 kind;
  logic [BYTE_W-1:0]    payload_byte;
  logic [ADDR_W-1:0]    byte_index;
  logic                 last;
  logic [CNT_W-1:0]     good_count;
  logic [CNT_W-1:0]     error_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  int                   fail_count;
  int                   pending;

  // Stimulus bookkeeping
  logic [LEN_W-1:0]  len_now = 7'd16;
  logic [BYTE_W-1:0] id_now  = 8'h02;
  int unsigned       burst_left = 0;
  bit                sender_quiet = 1'b0;
  int unsigned       phase_bytes = 0;
  int unsigned       cycles = 0;
  int unsigned       stall_left = 0;
  int unsigned       stall_mode = 0;

  sync_header_frame_parser i_dut (.*);
  sfp_checker i_checker (.*);

  always #5ns clk = ~clk;

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall: one of four modes, each held for a random stretch before the next
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      2:       out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  function automatic int unsigned frame_len(input logic [LEN_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_PAYLOAD) return MAX_PAYLOAD;
    return r;
  endfunction

  // One byte on the input channel; bursts with random gaps between them
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!sender_quiet && $urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PAYLOAD_LENGTH) len_now = d[LEN_W-1:0];
    else if (idx == CFG_MESSAGE_ID) id_now = d;
  endtask

  // Drop valid, wait for every predicted item, then let the parser settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Build and send one frame, or a broken piece of one; fill < 0 gives random payload
  task automatic send_frame(input frame_kind_t fk, input int fill);
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] flip;
    int unsigned       n;
    int unsigned       cut;
    n    = frame_len(len_now);
    flip = BYTE_W'($urandom_range(1, 255));
    cut  = (fk == FR_BROKEN_SYNC) ? $urandom_range(0, 3) : 4;
    if (fk == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) b = SYNC_WORD[31 -: 8];
        else b = BYTE_W'($urandom_range(0, 255));
        seq.push_back(b);
      end
    end else begin
      for (int i = 0; i < cut; i++) seq.push_back(SYNC_WORD[31 - 8*i -: 8]);
      if (fk == FR_BROKEN_SYNC) begin
        // wrong sync byte; a '$' here must not restart the frame
        if (cut > 0 && $urandom_range(0, 1) == 1) b = SYNC_WORD[31 -: 8];
        else b = SYNC_WORD[31 - 8*cut -: 8] ^ flip;
        seq.push_back(b);
      end else begin
        b = BYTE_W'(n + 1);
        if (fk == FR_BAD_LEN) b = b ^ flip;
        seq.push_back(b);
        sum = BYTE_W'(n + 1) + id_now;
        if (fk != FR_BAD_LEN) begin
          b = (fk == FR_BAD_ID) ? id_now ^ flip : id_now;
          seq.push_back(b);
          if (fk != FR_BAD_ID) begin
            for (int i = 0; i < n; i++) begin
              if (fill < 0) b = BYTE_W'($urandom_range(0, 255));
              else b = BYTE_W'(fill);
              sum = sum + b;
              seq.push_back(b);
            end
            b = (fk == FR_BAD_SUM) ? sum ^ flip : sum;
            seq.push_back(b);
            b = (fk == FR_BAD_END) ? TERMINATOR ^ flip : TERMINATOR;
            seq.push_back(b);
          end
        end
      end
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic frame_kind_t pick_frame();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) return FR_GOOD;
    if (roll < 70) return FR_BAD_SUM;
    if (roll < 78) return FR_BAD_END;
    if (roll < 83) return FR_BAD_LEN;
    if (roll < 88) return FR_BAD_ID;
    if (roll < 94) return FR_BROKEN_SYNC;
    return FR_NOISE;
  endfunction

  initial begin
    logic [BYTE_W-1:0] len_val;
    logic [BYTE_W-1:0] id_val;
    logic [BYTE_W-1:0] sum;
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: length register 0 acts as 1, ID at its top value, spare index ignored
    write_reg(CFG_SPARE, 8'hA5);
    write_reg(CFG_PAYLOAD_LENGTH, 8'h00);
    write_reg(CFG_MESSAGE_ID, 8'hFF);
    send_frame(FR_GOOD, 8'h00);
    send_frame(FR_GOOD, 8'hFF);
    // a second '$' after the first is dropped, so the rest of the header is lost
    send_byte(SYNC_WORD[31 -: 8]);
    send_byte(SYNC_WORD[31 -: 8]);
    send_byte(SYNC_WORD[23 -: 8]);
    send_byte(SYNC_WORD[15 -: 8]);
    send_byte(SYNC_WORD[7 -: 8]);
    send_frame(FR_BAD_SUM, -1);
    send_frame(FR_BAD_END, -1);
    send_frame(FR_BAD_LEN, -1);
    send_frame(FR_BAD_ID, -1);

    // Length raised from 2 to 3 in the middle of the payload
    wait_idle();
    write_reg(CFG_PAYLOAD_LENGTH, 8'd2);
    for (int i = 0; i < 4; i++) send_byte(SYNC_WORD[31 - 8*i -: 8]);
    send_byte(8'd3);
    send_byte(id_now);
    send_byte(8'hA5);
    wait_idle();
    write_reg(CFG_PAYLOAD_LENGTH, 8'd3);
    send_byte(8'h5A);
    send_byte(8'h3C);
    sum = 8'd3 + id_now + 8'hA5 + 8'h5A + 8'h3C;
    send_byte(sum);
    send_byte(TERMINATOR);

    // Random phases, each with its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0:       len_val = 8'd1;
        1:       len_val = 8'd64;
        2:       len_val = 8'h80;   // bit 7 dropped, acts as 1
        3:       len_val = 8'hFF;   // 127, acts as 64
        4:       len_val = 8'd0;
        default: len_val = BYTE_W'($urandom_range(2, 8));
      endcase
      case (p)
        0:       id_val = 8'h00;
        1:       id_val = 8'hFF;
        default: id_val = BYTE_W'($urandom_range(0, 255));
      endcase
      write_reg(CFG_PAYLOAD_LENGTH, len_val);
      write_reg(CFG_MESSAGE_ID, id_val);
      sender_quiet = ($urandom_range(0, 3) == 0);
      phase_bytes  = 0;
      while (phase_bytes < PHASE_BYTES) send_frame(pick_frame(), -1);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
